[hw/rtl/gdbd_pkg.sv]
// ----------------------------------------------------------------------------
// gdbd_pkg
// Types, status codes and date arithmetic helpers for the days-between core.
// ----------------------------------------------------------------------------
package gdbd_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 19;
    localparam int SERIAL_W = 23;   // covers year 16383 day 31 of month 12

    localparam logic [YEAR_W:0]    SPAN_YEARS = 15'd1000;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SPAN  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ORDER = 2'd2;

    typedef struct packed {
        logic [YEAR_W-1:0]  start_year;
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
        logic [YEAR_W-1:0]  end_year;
        logic [MONTH_W-1:0] end_month;
        logic [DAY_W-1:0]   end_day;
    } query_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  day_count;
    } answer_t;

    // floor(n / 25) for n < 8192 via reciprocal multiply (5243 / 2^17)
    function automatic logic [8:0] div25(input logic [12:0] n);
        logic [25:0] prod;
        prod = {13'd0, n} * 26'd5243;
        return prod[25:17];
    endfunction

    // Days in the year before the first of the month; idx 0 is January
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] idx);
        logic [8:0] d;
        case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [8:0]        q100;
        logic [YEAR_W-1:0] hund;
        q100 = div25({1'b0, y[YEAR_W-1:2]});
        hund = YEAR_W'({5'd0, q100} * 14'd100);
        return (y[1:0] == 2'b00) && ((y != hund) || (q100[1:0] == 2'b00));
    endfunction

    // Days from the first day of year 0 to (y, m, d), plus one.
    // Month 0 counts as January, months above 12 as December.
    function automatic logic [SERIAL_W-1:0] day_serial(
        input logic [YEAR_W-1:0]  y,
        input logic [MONTH_W-1:0] m,
        input logic [DAY_W-1:0]   d
    );
        logic [YEAR_W:0]      y3;
        logic [YEAR_W:0]      y99;
        logic [YEAR_W:0]      y399;
        logic [12:0]          q4;
        logic [8:0]           q100;
        logic [8:0]           q400;
        logic [12:0]          leaps;
        logic [MONTH_W-1:0]   mm;
        logic [SERIAL_W-1:0]  s;
        y3    = {1'b0, y} + 15'd3;
        y99   = {1'b0, y} + 15'd99;
        y399  = {1'b0, y} + 15'd399;
        q4    = y3[YEAR_W:2];
        q100  = div25(y99[YEAR_W:2]);
        q400  = div25({2'd0, y399[YEAR_W:4]});
        leaps = q4 - {4'd0, q100} + {4'd0, q400};
        if (m == 4'd0)
            mm = 4'd1;
        else if (m > 4'd12)
            mm = 4'd12;
        else
            mm = m;
        s = {9'd0, y} * 23'd365
          + {10'd0, leaps}
          + {14'd0, days_before(mm - 4'd1)}
          + {18'd0, d}
          + {22'd0, (mm > 4'd2) && is_leap(y)};
        return s;
    endfunction

endpackage

[hw/rtl/gdbd_chan_if.sv]
// ----------------------------------------------------------------------------
// gdbd_chan_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface gdbd_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/gregorian_days_between_dates_core.sv]
// ----------------------------------------------------------------------------
// gregorian_days_between_dates_core
// Day count between two Gregorian dates, one query per beat.
//
// Each req beat carries a start and an end date; each rsp beat carries a
// status and the number of days from start to end. Status ST_SPAN is given
// when the end falls on or after the start moved forward 1000 years
// (compared year, month, day), ST_ORDER when the end precedes the start;
// day_count is zero for both. An accepted query passes the input register,
// then the result register; one query is accepted every cycle while rsp
// does not stall. The day-serial conversion is combinational and uses only
// multiplies by constants. Backpressure on rsp stalls
// the pipe; req.ready stays high as long as a register slot is free.
// ----------------------------------------------------------------------------
module gregorian_days_between_dates_core (
    input logic clk,
    input logic rst_n,
    gdbd_chan_if.sink   req,
    gdbd_chan_if.source rsp
);

    // Input stage
    logic                 s1_valid_reg;
    gdbd_pkg::query_t     s1_data_reg;
    // Result stage
    logic                 out_valid_reg;
    gdbd_pkg::answer_t    out_data_reg;

    logic                 out_free;
    logic                 s1_move;
    logic                 req_beat;

    gdbd_pkg::answer_t    ans_next;
    logic [gdbd_pkg::YEAR_W:0]     span_year;
    logic                          past_span;
    logic                          before_start;
    logic [gdbd_pkg::SERIAL_W-1:0] ser_a;
    logic [gdbd_pkg::SERIAL_W-1:0] ser_b;
    logic [gdbd_pkg::SERIAL_W-1:0] diff;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign s1_move   = s1_valid_reg && out_free;
    assign req.ready = !s1_valid_reg || out_free;
    assign req_beat  = req.valid && req.ready;

    // Lexicographic compares: fixed-width fields concatenate in order.
    always_comb
    begin
        span_year    = {1'b0, s1_data_reg.start_year} + gdbd_pkg::SPAN_YEARS;
        past_span    = {1'b0, s1_data_reg.end_year, s1_data_reg.end_month,
                        s1_data_reg.end_day}
                    >= {span_year, s1_data_reg.start_month, s1_data_reg.start_day};
        before_start = {s1_data_reg.end_year, s1_data_reg.end_month,
                        s1_data_reg.end_day}
                     < {s1_data_reg.start_year, s1_data_reg.start_month,
                        s1_data_reg.start_day};
        ser_a = gdbd_pkg::day_serial(s1_data_reg.start_year, s1_data_reg.start_month,
                                     s1_data_reg.start_day);
        ser_b = gdbd_pkg::day_serial(s1_data_reg.end_year, s1_data_reg.end_month,
                                     s1_data_reg.end_day);
        diff  = ser_b - ser_a;

        ans_next.day_count = '0;
        if (past_span)
        begin
            ans_next.status = gdbd_pkg::ST_SPAN;
        end
        else if (before_start)
        begin
            ans_next.status = gdbd_pkg::ST_ORDER;
        end
        else
        begin
            ans_next.status = gdbd_pkg::ST_OK;
            // Out-of-range days can make the serial difference negative
            if (ser_b > ser_a)
            begin
                if (diff > {4'd0, gdbd_pkg::COUNT_MAX})
                    ans_next.day_count = gdbd_pkg::COUNT_MAX;
                else
                    ans_next.day_count = diff[gdbd_pkg::COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                s1_valid_reg <= req.valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_beat)
            s1_data_reg <= req.data;
        if (s1_move)
            out_data_reg <= ans_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_err_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.status != gdbd_pkg::ST_OK) |-> rsp.data.day_count == '0)
        else $error("nonzero day_count with error status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.data.status == gdbd_pkg::ST_OK ||
                       rsp.data.status == gdbd_pkg::ST_SPAN ||
                       rsp.data.status == gdbd_pkg::ST_ORDER))
        else $error("undefined status code");

    a_beat_lands: assert property (@(posedge clk) disable iff (!rst_n)
        req_beat |=> s1_valid_reg)
        else $error("accepted beat lost in input stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !rsp.ready) |=>
            (s1_valid_reg && $stable(s1_data_reg)))
        else $error("input stage dropped during result stall");

endmodule

[sim/gdbd_answer_board_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gdbd_answer_board_pkg
// Predicts status and day count for each accepted date-pair beat and
// compares every result beat with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
package gdbd_answer_board_pkg;

    localparam int unsigned SHOWN_FAULTS = 10;

    class answer_board;

        gdbd_pkg::answer_t awaited[$];
        int unsigned       fault_count;
        int unsigned cum_days[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

        function new();
            fault_count = 0;
        endfunction

        static function bit leap_year(int unsigned y);
            return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
        endfunction

        // Day number counted from year 0, Jan 1 being day 1 of year 0
        function int unsigned serial_day(int unsigned y, int unsigned m, int unsigned d);
            int unsigned mm;
            int unsigned s;
            mm = (m < 1) ? 1 : ((m > 12) ? 12 : m);
            s  = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
            s += cum_days[mm - 1];
            if (mm > 2 && leap_year(y))
                s += 1;
            return s + d;
        endfunction

        // Lexicographic year/month/day compare on raw field values
        function bit same_or_later(int unsigned ay, int unsigned am, int unsigned ad,
                                   int unsigned by, int unsigned bm, int unsigned bd);
            if (ay != by)
                return ay > by;
            if (am != bm)
                return am > bm;
            return ad >= bd;
        endfunction

        function gdbd_pkg::answer_t span_answer(gdbd_pkg::query_t q);
            gdbd_pkg::answer_t a;
            int unsigned sy, sm, sd, ey, em, ed;
            int unsigned from_day, to_day, gap;
            sy = q.start_year;
            sm = q.start_month;
            sd = q.start_day;
            ey = q.end_year;
            em = q.end_month;
            ed = q.end_day;
            a.day_count = '0;
            if (same_or_later(ey, em, ed, sy + 1000, sm, sd))
            begin
                a.status = gdbd_pkg::ST_SPAN;
            end
            else if (!same_or_later(ey, em, ed, sy, sm, sd))
            begin
                a.status = gdbd_pkg::ST_ORDER;
            end
            else
            begin
                a.status = gdbd_pkg::ST_OK;
                from_day = serial_day(sy, sm, sd);
                to_day   = serial_day(ey, em, ed);
                if (to_day > from_day)
                begin
                    gap = to_day - from_day;
                    if (gap > gdbd_pkg::COUNT_MAX)
                        gap = gdbd_pkg::COUNT_MAX;
                    a.day_count = gap[gdbd_pkg::COUNT_W-1:0];
                end
            end
            return a;
        endfunction

        function void note(gdbd_pkg::query_t q);
            awaited.push_back(span_answer(q));
        endfunction

        function void check(gdbd_pkg::answer_t got);
            gdbd_pkg::answer_t want;
            if (awaited.size() == 0)
            begin
                fault_count++;
                if (fault_count <= SHOWN_FAULTS)
                    $display("[%0t] unexpected result beat: status %0d day_count %0d",
                             $time, got.status, got.day_count);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.day_count !== want.day_count)
            begin
                fault_count++;
                if (fault_count <= SHOWN_FAULTS)
                    $display("[%0t] mismatch: status exp %0d got %0d, day_count exp %0d got %0d",
                             $time, want.status, got.status, want.day_count, got.day_count);
            end
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

    endclass

endpackage

[sim/gregorian_days_between_dates_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gregorian_days_between_dates_core_tb
// Drives date-pair beats into the days-between core and checks every result.
//
// A directed set covers the field extremes, the leap-year rules, the
// 1000-year boundary, end-before-start, year zero and years past 9999,
// out-of-range months and days, and a day offset that runs backwards.
// Random beats follow in four phases of sender idle and receiver stall;
// most are valid dates, some sit on the span boundary or on leap days, and the rest are raw bit noise.
// ----------------------------------------------------------------------------
module gregorian_days_between_dates_core_tb;

    localparam int unsigned ITEMS_PER_PHASE = 350;
    localparam int unsigned QUIET_LIMIT     = 5000;  // cycles with no beat at all
    localparam int unsigned DRAIN_CYCLES    = 20;

    logic clk;
    logic rst_n;

    gdbd_chan_if #(.T(gdbd_pkg::query_t))  req_if ();
    gdbd_chan_if #(.T(gdbd_pkg::answer_t)) rsp_if ();

    gregorian_days_between_dates_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    gdbd_answer_board_pkg::answer_board board;

    int unsigned src_idle   = 0;    // percent of cycles the sender holds off
    int unsigned sink_stall = 0;    // percent of cycles the receiver stalls
    int unsigned quiet_cycles = 0;

    int unsigned idle_by_phase[4]  = '{0, 67, 0, 34};
    int unsigned stall_by_phase[4] = '{0, 0, 67, 34};

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor: both channels are sampled at the rising edge, before the core's
    // nonblocking updates land, so every beat seen here is a real handshake.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
                board.note(req_if.data);
            if (rsp_if.valid && rsp_if.ready)
                board.check(rsp_if.data);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: a long run with no beat on either side means the core hung
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Receiver: ready changes only at the falling edge
    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_if.ready = rst_n && ($urandom_range(99) >= sink_stall);
        end
    end

    // ------------------------------------------------------------------------
    // Sender: called at a falling edge, returns at the falling edge after the
    // beat is taken. Valid stays high across back-to-back beats.
    // ------------------------------------------------------------------------
    task automatic send(input gdbd_pkg::query_t q);
        while ($urandom_range(99) < src_idle)
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid = 1'b1;
        req_if.data  = q;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_dates(input int unsigned sy, input int unsigned sm,
                              input int unsigned sd, input int unsigned ey,
                              input int unsigned em, input int unsigned ed);
        gdbd_pkg::query_t q;
        q.start_year  = sy[gdbd_pkg::YEAR_W-1:0];
        q.start_month = sm[gdbd_pkg::MONTH_W-1:0];
        q.start_day   = sd[gdbd_pkg::DAY_W-1:0];
        q.end_year    = ey[gdbd_pkg::YEAR_W-1:0];
        q.end_month   = em[gdbd_pkg::MONTH_W-1:0];
        q.end_day     = ed[gdbd_pkg::DAY_W-1:0];
        send(q);
    endtask

    function automatic int unsigned month_len(int unsigned y, int unsigned m);
        case (m)
            2:             return gdbd_answer_board_pkg::answer_board::leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // Random date pair; the mix leans on well-formed dates
    task automatic send_random();
        int unsigned      sy, sm, sd, ey, em, ed;
        int unsigned      pick;
        logic [63:0]      noise;
        gdbd_pkg::query_t q;
        pick = $urandom_range(99);
        sy = $urandom_range(1, 9999);
        sm = $urandom_range(1, 12);
        sd = $urandom_range(1, month_len(sy, sm));
        if (pick < 45)
        begin
            // ordinary span inside 1000 years
            ey = sy + $urandom_range(0, 999);
            if (ey > 9999)
                ey = 9999;
            em = $urandom_range(1, 12);
            ed = $urandom_range(1, month_len(ey, em));
        end
        else if (pick < 60)
        begin
            // right at the 1000-year boundary
            sy = $urandom_range(1, 8999);
            sd = $urandom_range(1, month_len(sy, sm));
            ey = sy + 1000 - $urandom_range(0, 1);
            case ($urandom_range(2))
                0:
                begin
                    em = sm;
                    ed = sd;
                end
                1:
                begin
                    em = sm;
                    ed = (sd > 1) ? sd - 1 : sd;
                end
                default:
                begin
                    em = $urandom_range(1, 12);
                    ed = $urandom_range(1, month_len(ey, em));
                end
            endcase
        end
        else if (pick < 72)
        begin
            // end before start
            ey = $urandom_range(1, sy);
            em = $urandom_range(1, 12);
            ed = $urandom_range(1, month_len(ey, em));
        end
        else if (pick < 85)
        begin
            // short span around February of 400-year, century and other years
            case ($urandom_range(2))
                0:       sy = 400 * $urandom_range(1, 24);
                1:       sy = 100 * $urandom_range(1, 99);
                default: sy = 4 * $urandom_range(1, 2499) + $urandom_range(0, 3);
            endcase
            sm = $urandom_range(1, 3);
            sd = $urandom_range(1, month_len(sy, sm));
            ey = sy + $urandom_range(0, 1);
            em = $urandom_range(2, 4);
            ed = $urandom_range(1, month_len(ey, em));
        end
        else
        begin
            // raw noise over every bit of every field
            noise = {$urandom, $urandom};
            q = noise[$bits(gdbd_pkg::query_t)-1:0];
            send(q);
            return;
        end
        send_dates(sy, sm, sd, ey, em, ed);
    endtask

    task automatic send_directed();
        send_dates(2000, 2, 29, 2000, 2, 29);       // same day
        send_dates(1, 1, 1, 9999, 12, 31);          // widest valid span
        send_dates(2024, 3, 1, 2024, 2, 29);        // one day backwards
        send_dates(1500, 6, 15, 2500, 6, 15);       // exactly 1000 years
        send_dates(1500, 6, 15, 2500, 6, 14);       // a day short of it
        send_dates(1, 1, 1, 1000, 12, 31);          // largest count
        send_dates(1900, 2, 28, 1900, 3, 1);        // century, not leap
        send_dates(2000, 2, 28, 2000, 3, 1);        // 400-year leap
        send_dates(2023, 12, 31, 2024, 1, 1);       // year rollover
        send_dates(0, 1, 1, 0, 12, 31);             // year zero
        send_dates(0, 0, 0, 0, 0, 0);               // all fields zero
        send_dates(15400, 1, 1, 16383, 12, 31);     // years past 9999
        send_dates(16383, 15, 31, 16383, 15, 31);   // all ones
        send_dates(16383, 15, 31, 0, 0, 0);         // all ones back to zero
        send_dates(2023, 0, 5, 2023, 1, 5);         // month zero reads as January
        send_dates(2023, 12, 1, 2023, 14, 20);      // month past twelve
        send_dates(2023, 2, 31, 2023, 3, 1);        // offset runs backwards
        send_dates(2024, 2, 30, 2024, 3, 1);        // day past month end
        send_dates(2023, 3, 0, 2023, 3, 1);         // day zero
        send_dates(9999, 12, 31, 9999, 12, 31);     // top valid date
        send_dates(8999, 12, 31, 9999, 12, 31);     // span at the top
    endtask

    // ------------------------------------------------------------------------
    // Main flow: reset, directed set, four random phases, drain, verdict.
    // ------------------------------------------------------------------------
    initial
    begin
        board = new();
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_directed();
        for (int p = 0; p < 4; p++)
        begin
            src_idle   = idle_by_phase[p];
            sink_stall = stall_by_phase[p];
            for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++)
                send_random();
        end
        req_if.valid = 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.fault_count == 0 && board.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
